[rtl/hefd_pkg.sv]
// Shared types, constants and helpers of the humidity exhaust fan duty block.
package hefd_pkg;

  localparam int DutyW     = 8;
  localparam int PctW      = 7;
  localparam int ThrW      = 15;
  localparam int ErrW      = 16;
  localparam int CmdW      = 2;
  localparam int CfgAddrW  = 5;
  localparam int CfgDataW  = 32;
  localparam int CfgIdxW   = 3;
  localparam int DivDendW  = 23;
  localparam int DivDsorW  = 15;

  typedef enum logic [CmdW-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_MANUAL = 2'd1,
    CMD_ALARM  = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_SPEED   = 3'd0,
    REG_MAX_SPEED   = 3'd1,
    REG_STALL_DUTY  = 3'd2,
    REG_HUMID_DEAD  = 3'd3,
    REG_HUMID_FULL  = 3'd4,
    REG_TEMP_LOW    = 3'd5,
    REG_TEMP_HIGH   = 3'd6
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_HDIV,
    ST_TEMP,
    ST_TDIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DutyW-1:0] min_speed;
    logic [DutyW-1:0] max_speed;
    logic [DutyW-1:0] stall_duty;
    logic [ThrW-1:0]  humid_deadband;
    logic [ThrW-1:0]  humid_full_range;
    logic [ThrW-1:0]  temp_protect_low;
    logic [ThrW-1:0]  temp_protect_high;
  } cfg_t;

  localparam logic [DutyW-1:0] RstMinSpeed  = 8'd0;
  localparam logic [DutyW-1:0] RstMaxSpeed  = 8'd255;
  localparam logic [DutyW-1:0] RstStallDuty = 8'd40;
  localparam logic [ThrW-1:0]  RstHumidDead = 15'd512;
  localparam logic [ThrW-1:0]  RstHumidFull = 15'd3840;
  localparam logic [ThrW-1:0]  RstTempLow   = 15'd128;
  localparam logic [ThrW-1:0]  RstTempHigh  = 15'd512;

  // floor(d * 100 / 255); x/255 == (x + (x >> 8) + 1) >> 8 holds for x below 65535
  function automatic logic [PctW-1:0] duty_to_pct(input logic [DutyW-1:0] d);
    logic [15:0] p;
    logic [15:0] s;
    p = 16'(d) * 16'd100;
    s = p + (p >> 8) + 16'd1;
    return s[14:8];
  endfunction

endpackage

[rtl/hefd_if.sv]
// Valid/ready channel interfaces for command items and duty results.
interface hefd_in_if;
  logic                               valid;
  logic                               ready;
  logic [hefd_pkg::CmdW-1:0]          command;
  logic signed [hefd_pkg::ErrW-1:0]   temp_error;
  logic signed [hefd_pkg::ErrW-1:0]   humid_error;
  logic signed [hefd_pkg::ErrW-1:0]   manual_request;

  modport source (output valid, command, temp_error, humid_error, manual_request,
                  input ready);
  modport sink   (input valid, command, temp_error, humid_error, manual_request,
                  output ready);
endinterface

interface hefd_out_if;
  logic                        valid;
  logic                        ready;
  logic [hefd_pkg::DutyW-1:0]  duty;
  logic [hefd_pkg::PctW-1:0]   duty_percent;

  modport source (output valid, duty, duty_percent, input ready);
  modport sink   (input valid, duty, duty_percent, output ready);
endinterface

[rtl/hefd_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module hefd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [hefd_pkg::DivDendW-1:0] dividend_i,
  input  logic [hefd_pkg::DivDsorW-1:0] divisor_i,
  output logic                          done_o,
  output logic [hefd_pkg::DivDendW-1:0] quotient_o
);

  localparam int DW = hefd_pkg::DivDendW;
  localparam int VW = hefd_pkg::DivDsorW;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          ge;
  logic [VW-1:0] rem_nx;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
    rem_nx  = ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/hefd_cfg.sv]
// APB-style register file holding the fan duty configuration.
module hefd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [hefd_pkg::CfgAddrW-1:0] paddr_i,
  input  logic [hefd_pkg::CfgDataW-1:0] pwdata_i,
  output logic [hefd_pkg::CfgDataW-1:0] prdata_o,
  output logic                          pready_o,
  output hefd_pkg::cfg_t                cfg_o
);

  hefd_pkg::cfg_t                cfg_q;
  logic [hefd_pkg::CfgIdxW-1:0]  idx;
  logic                          wr;

  assign idx      = paddr_i[hefd_pkg::CfgAddrW-1:2];
  assign pready_o = 1'b1;
  assign wr       = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_speed         <= hefd_pkg::RstMinSpeed;
      cfg_q.max_speed         <= hefd_pkg::RstMaxSpeed;
      cfg_q.stall_duty        <= hefd_pkg::RstStallDuty;
      cfg_q.humid_deadband    <= hefd_pkg::RstHumidDead;
      cfg_q.humid_full_range  <= hefd_pkg::RstHumidFull;
      cfg_q.temp_protect_low  <= hefd_pkg::RstTempLow;
      cfg_q.temp_protect_high <= hefd_pkg::RstTempHigh;
    end else if (wr) begin
      unique case (idx)
        hefd_pkg::REG_MIN_SPEED:  cfg_q.min_speed         <= pwdata_i[hefd_pkg::DutyW-1:0];
        hefd_pkg::REG_MAX_SPEED:  cfg_q.max_speed         <= pwdata_i[hefd_pkg::DutyW-1:0];
        hefd_pkg::REG_STALL_DUTY: cfg_q.stall_duty        <= pwdata_i[hefd_pkg::DutyW-1:0];
        hefd_pkg::REG_HUMID_DEAD: cfg_q.humid_deadband    <= pwdata_i[hefd_pkg::ThrW-1:0];
        hefd_pkg::REG_HUMID_FULL: cfg_q.humid_full_range  <= pwdata_i[hefd_pkg::ThrW-1:0];
        hefd_pkg::REG_TEMP_LOW:   cfg_q.temp_protect_low  <= pwdata_i[hefd_pkg::ThrW-1:0];
        hefd_pkg::REG_TEMP_HIGH:  cfg_q.temp_protect_high <= pwdata_i[hefd_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hefd_pkg::REG_MIN_SPEED:  prdata_o = hefd_pkg::CfgDataW'(cfg_q.min_speed);
      hefd_pkg::REG_MAX_SPEED:  prdata_o = hefd_pkg::CfgDataW'(cfg_q.max_speed);
      hefd_pkg::REG_STALL_DUTY: prdata_o = hefd_pkg::CfgDataW'(cfg_q.stall_duty);
      hefd_pkg::REG_HUMID_DEAD: prdata_o = hefd_pkg::CfgDataW'(cfg_q.humid_deadband);
      hefd_pkg::REG_HUMID_FULL: prdata_o = hefd_pkg::CfgDataW'(cfg_q.humid_full_range);
      hefd_pkg::REG_TEMP_LOW:   prdata_o = hefd_pkg::CfgDataW'(cfg_q.temp_protect_low);
      hefd_pkg::REG_TEMP_HIGH:  prdata_o = hefd_pkg::CfgDataW'(cfg_q.temp_protect_high);
      default:                  prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/humidity_exhaust_fan_duty.sv]
// Humidity exhaust fan duty controller: one duty result per command item. Manual, alarm,
// release and unused commands, updates in manual mode, and updates below the humidity deadband
// reach the output register without a divider pass. An automatic update that needs the
// humidity ratio runs one pass of the shared 23-step bit-serial divider, and one that is
// throttled by temperature runs a pass for the throttle as well. The input is not ready while
// an item is in work. The result sits in an output register, and a finished item waits only
// if the previous result is still untaken.
module humidity_exhaust_fan_duty (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hefd_in_if.sink                       cmd_i,
  hefd_out_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hefd_pkg::CfgAddrW-1:0] paddr,
  input  logic [hefd_pkg::CfgDataW-1:0] pwdata,
  output logic [hefd_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  localparam int DutyW = hefd_pkg::DutyW;
  localparam int ThrW  = hefd_pkg::ThrW;
  localparam int ErrW  = hefd_pkg::ErrW;

  hefd_pkg::cfg_t   cfg;
  hefd_pkg::state_e state_q, state_d;

  // item registers
  logic [hefd_pkg::CmdW-1:0]  cmd_q;
  logic signed [ErrW-1:0]     terr_q;
  logic signed [ErrW-1:0]     herr_q;
  logic signed [ErrW-1:0]     req_q;

  logic                       manual_on_q;
  logic [DutyW-1:0]           manual_duty_q;
  logic [DutyW-1:0]           cur_duty_q;
  logic [DutyW-1:0]           duty_q;
  logic [DutyW-1:0]           lo_q;

  logic                       out_valid_q;
  logic [DutyW-1:0]           out_duty_q;
  logic [hefd_pkg::PctW-1:0]  out_pct_q;

  // divider
  logic                             div_start;
  logic [hefd_pkg::DivDendW-1:0]    div_dend;
  logic [hefd_pkg::DivDsorW-1:0]    div_dsor;
  logic                             div_done;
  logic [hefd_pkg::DivDendW-1:0]    div_quo;

  // control
  logic in_ready;
  logic out_load;

  // humidity path
  logic [DutyW-1:0]           emin, lo, hi, span;
  logic signed [ErrW:0]       excess;
  logic signed [ErrW:0]       hnum_full;
  logic signed [ErrW:0]       hden_full;
  logic                       below_dead;
  logic                       hsat;
  logic [ErrW-1:0]            hnum;
  logic [23:0]                hprod;

  // temperature path
  logic                       t_off;
  logic                       t_throttle;
  logic [ErrW-1:0]            tnum_full;
  logic [ThrW-1:0]            tden;
  logic [22:0]                tprod;
  logic [DutyW-1:0]           tq;

  hefd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  hefd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dend),
    .divisor_i  (div_dsor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    emin = (cfg.min_speed > cfg.max_speed) ? cfg.max_speed : cfg.min_speed;
    lo   = (emin > cfg.stall_duty) ? emin : cfg.stall_duty;
    hi   = (cfg.max_speed > lo) ? cfg.max_speed : lo;
    span = hi - lo;

    excess     = -$signed({herr_q[ErrW-1], herr_q});
    hnum_full  = excess - $signed({2'b00, cfg.humid_deadband});
    hden_full  = $signed({2'b00, cfg.humid_full_range})
               - $signed({2'b00, cfg.humid_deadband});
    below_dead = excess <= $signed({2'b00, cfg.humid_deadband});
    // full range at or under the deadband counts as full duty
    hsat       = (cfg.humid_full_range <= cfg.humid_deadband) || (hnum_full >= hden_full);
    hnum       = hnum_full[ErrW-1:0];
    hprod      = 24'(span) * 24'(hnum);

    t_off      = terr_q > $signed({1'b0, cfg.temp_protect_high});
    t_throttle = terr_q > $signed({1'b0, cfg.temp_protect_low});
    tnum_full  = {1'b0, cfg.temp_protect_high} - terr_q;
    tden       = cfg.temp_protect_high - cfg.temp_protect_low;
    tprod      = 23'(duty_q) * 23'(tnum_full[ThrW-1:0]);
    tq         = div_quo[DutyW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hefd_pkg::ST_IDLE: if (cmd_i.valid) state_d = hefd_pkg::ST_CALC;
      hefd_pkg::ST_CALC: begin
        if (cmd_q == hefd_pkg::CMD_UPDATE && !manual_on_q && !below_dead) begin
          state_d = hsat ? hefd_pkg::ST_TEMP : hefd_pkg::ST_HDIV;
        end else begin
          state_d = hefd_pkg::ST_DONE;
        end
      end
      hefd_pkg::ST_HDIV: if (div_done) state_d = hefd_pkg::ST_TEMP;
      hefd_pkg::ST_TEMP: begin
        state_d = (!t_off && t_throttle) ? hefd_pkg::ST_TDIV : hefd_pkg::ST_DONE;
      end
      hefd_pkg::ST_TDIV: if (div_done) state_d = hefd_pkg::ST_DONE;
      hefd_pkg::ST_DONE: if (!out_valid_q || res_o.ready) state_d = hefd_pkg::ST_IDLE;
      default: state_d = hefd_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    div_dend  = '0;
    div_dsor  = '0;
    unique case (state_q)
      hefd_pkg::ST_IDLE: in_ready = 1'b1;
      hefd_pkg::ST_CALC: begin
        div_start = cmd_q == hefd_pkg::CMD_UPDATE && !manual_on_q && !below_dead && !hsat;
        div_dend  = hprod[hefd_pkg::DivDendW-1:0];
        div_dsor  = hden_full[hefd_pkg::DivDsorW-1:0];
      end
      hefd_pkg::ST_TEMP: begin
        div_start = !t_off && t_throttle;
        div_dend  = tprod;
        div_dsor  = tden;
      end
      hefd_pkg::ST_DONE: out_load = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= hefd_pkg::ST_IDLE;
      manual_on_q   <= 1'b0;
      manual_duty_q <= '0;
      cur_duty_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == hefd_pkg::ST_CALC) begin
        unique case (cmd_q)
          hefd_pkg::CMD_MANUAL: begin
            if (req_q < 0) begin
              manual_on_q   <= 1'b0;
              manual_duty_q <= '0;
            end else begin
              manual_on_q   <= 1'b1;
              manual_duty_q <= (req_q > 255) ? DutyW'(255) : req_q[DutyW-1:0];
            end
          end
          hefd_pkg::CMD_ALARM: begin
            manual_on_q   <= 1'b1;
            manual_duty_q <= cfg.max_speed;
          end
          default: ;
        endcase
      end
      if (out_load) begin
        cur_duty_q  <= duty_q;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_ready && cmd_i.valid) begin
      cmd_q  <= cmd_i.command;
      terr_q <= cmd_i.temp_error;
      herr_q <= cmd_i.humid_error;
      req_q  <= cmd_i.manual_request;
    end
    unique case (state_q)
      hefd_pkg::ST_CALC: begin
        lo_q <= lo;
        unique case (cmd_q)
          hefd_pkg::CMD_UPDATE: begin
            if (manual_on_q)     duty_q <= manual_duty_q;
            else if (below_dead) duty_q <= '0;
            else                 duty_q <= hi;
          end
          hefd_pkg::CMD_MANUAL: begin
            if (req_q < 0)        duty_q <= cur_duty_q;
            else if (req_q > 255) duty_q <= DutyW'(255);
            else                  duty_q <= req_q[DutyW-1:0];
          end
          hefd_pkg::CMD_ALARM: duty_q <= cfg.max_speed;
          default:             duty_q <= cur_duty_q;
        endcase
      end
      hefd_pkg::ST_HDIV: if (div_done) duty_q <= lo_q + tq;
      hefd_pkg::ST_TEMP: if (t_off) duty_q <= '0;
      hefd_pkg::ST_TDIV: begin
        // a throttled duty that would not turn the motor stops it
        if (div_done) duty_q <= (tq != '0 && tq < cfg.stall_duty) ? '0 : tq;
      end
      default: ;
    endcase
    if (out_load) begin
      out_duty_q <= duty_q;
      out_pct_q  <= hefd_pkg::duty_to_pct(duty_q);
    end
  end

  assign cmd_i.ready        = in_ready;
  assign res_o.valid        = out_valid_q;
  assign res_o.duty         = out_duty_q;
  assign res_o.duty_percent = out_pct_q;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Testbench for the humidity exhaust fan duty block: directed and random items, APB set-up.
module testbench;

  localparam logic [hefd_pkg::CmdW-1:0] CmdUnused     = 2'd3;
  localparam int                        WatchdogLimit = 4000;
  localparam int                        NumPhases     = 7;
  localparam int                        ItemsPerPhase = 155;
  localparam int                        MaxPrinted    = 40;

  typedef struct {
    logic [hefd_pkg::CmdW-1:0]        command;
    logic signed [hefd_pkg::ErrW-1:0] temp_error;
    logic signed [hefd_pkg::ErrW-1:0] humid_error;
    logic signed [hefd_pkg::ErrW-1:0] manual_request;
  } fan_cmd_t;

  typedef struct {
    logic [hefd_pkg::DutyW-1:0] duty;
    logic [hefd_pkg::PctW-1:0]  pct;
  } fan_res_t;

  class fan_duty_scoreboard;
    hefd_pkg::cfg_t             regs;
    bit                         manual_on;
    logic [hefd_pkg::DutyW-1:0] manual_duty;
    logic [hefd_pkg::DutyW-1:0] applied_duty;
    fan_res_t                   duty_q[$];
    int                         mismatches;
    int                         results_seen;

    function new();
      regs.min_speed         = hefd_pkg::RstMinSpeed;
      regs.max_speed         = hefd_pkg::RstMaxSpeed;
      regs.stall_duty        = hefd_pkg::RstStallDuty;
      regs.humid_deadband    = hefd_pkg::RstHumidDead;
      regs.humid_full_range  = hefd_pkg::RstHumidFull;
      regs.temp_protect_low  = hefd_pkg::RstTempLow;
      regs.temp_protect_high = hefd_pkg::RstTempHigh;
      manual_on    = 1'b0;
      manual_duty  = '0;
      applied_duty = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(hefd_pkg::reg_e idx, logic [hefd_pkg::ThrW-1:0] v);
      case (idx)
        hefd_pkg::REG_MIN_SPEED:  regs.min_speed         = v[hefd_pkg::DutyW-1:0];
        hefd_pkg::REG_MAX_SPEED:  regs.max_speed         = v[hefd_pkg::DutyW-1:0];
        hefd_pkg::REG_STALL_DUTY: regs.stall_duty        = v[hefd_pkg::DutyW-1:0];
        hefd_pkg::REG_HUMID_DEAD: regs.humid_deadband    = v;
        hefd_pkg::REG_HUMID_FULL: regs.humid_full_range  = v;
        hefd_pkg::REG_TEMP_LOW:   regs.temp_protect_low  = v;
        hefd_pkg::REG_TEMP_HIGH:  regs.temp_protect_high = v;
        default: ;
      endcase
    endfunction

    // automatic duty from the humidity excess, then the cold throttle
    function logic [hefd_pkg::DutyW-1:0] auto_duty(int terr, int herr);
      int excess, dead, full, lo, hi, span, d, t_low, t_high;
      excess = -herr;
      dead   = regs.humid_deadband;
      full   = regs.humid_full_range;
      t_low  = regs.temp_protect_low;
      t_high = regs.temp_protect_high;
      if (excess <= dead) return '0;
      lo = (regs.min_speed > regs.max_speed) ? regs.max_speed : regs.min_speed;
      if (int'(regs.stall_duty) > lo) lo = regs.stall_duty;
      hi   = (int'(regs.max_speed) > lo) ? int'(regs.max_speed) : lo;
      span = hi - lo;
      if (full <= dead || excess - dead >= full - dead) begin
        d = lo + span;
      end else begin
        d = lo + (span * (excess - dead)) / (full - dead);
      end
      if (terr > t_high) begin
        d = 0;
      end else if (terr > t_low) begin
        d = (d * (t_high - terr)) / (t_high - t_low);
        if (d > 0 && d < int'(regs.stall_duty)) d = 0;
      end
      return d[hefd_pkg::DutyW-1:0];
    endfunction

    function void note_cmd(fan_cmd_t c);
      fan_res_t r;
      int       pct;
      case (c.command)
        hefd_pkg::CMD_UPDATE: begin
          applied_duty = manual_on ? manual_duty : auto_duty(c.temp_error, c.humid_error);
        end
        hefd_pkg::CMD_MANUAL: begin
          if (c.manual_request < 0) begin
            manual_on   = 1'b0;
            manual_duty = '0;
          end else begin
            manual_on    = 1'b1;
            manual_duty  = (c.manual_request > 255) ? 8'd255
                         : c.manual_request[hefd_pkg::DutyW-1:0];
            applied_duty = manual_duty;
          end
        end
        hefd_pkg::CMD_ALARM: begin
          manual_on    = 1'b1;
          manual_duty  = regs.max_speed;
          applied_duty = regs.max_speed;
        end
        default: ;
      endcase
      pct    = (int'(applied_duty) * 100) / 255;
      r.duty = applied_duty;
      r.pct  = pct[hefd_pkg::PctW-1:0];
      duty_q.push_back(r);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [hefd_pkg::DutyW-1:0] duty, logic [hefd_pkg::PctW-1:0] pct);
      fan_res_t want;
      results_seen++;
      if (duty_q.size() == 0) begin
        report($sformatf("result duty=%0d pct=%0d with no item pending", duty, pct));
        return;
      end
      want = duty_q.pop_front();
      if (duty !== want.duty)
        report($sformatf("result %0d: duty %0d, want %0d", results_seen, duty, want.duty));
      if (pct !== want.pct)
        report($sformatf("result %0d: duty_percent %0d, want %0d", results_seen, pct, want.pct));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel, penable, pwrite;
  logic [hefd_pkg::CfgAddrW-1:0] paddr;
  logic [hefd_pkg::CfgDataW-1:0] pwdata, prdata;
  logic                          pready;

  hefd_in_if  cmd_if ();
  hefd_out_if res_if ();

  humidity_exhaust_fan_duty dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fan_duty_scoreboard sb;
  bit no_stall = 1'b0;
  int quiet_cycles = 0;
  int n_update, n_set, n_release, n_alarm, n_unused, n_cfg;

  always #4 clk = ~clk;

  // watchdog: cycles in which nothing moves on any port
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_ni && res_if.valid && res_if.ready) sb.check_result(res_if.duty, res_if.duty_percent);
  end

  // result side back-pressure
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!no_stall && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 18)) begin
          @(negedge clk);
          res_if.ready <= 1'b0;
        end
      end
      repeat ($urandom_range(1, 30)) begin
        @(negedge clk);
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [hefd_pkg::ErrW-1:0] clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return hefd_pkg::ErrW'(v);
  endfunction

  function automatic fan_cmd_t mk(logic [hefd_pkg::CmdW-1:0] command, int terr, int herr,
                                  int req);
    fan_cmd_t c;
    c.command        = command;
    c.temp_error     = clip16(terr);
    c.humid_error    = clip16(herr);
    c.manual_request = clip16(req);
    return c;
  endfunction

  function automatic fan_cmd_t random_cmd();
    fan_cmd_t c;
    int sel, lo_e, hi_e, lo_t, hi_t;
    c.command        = hefd_pkg::CMD_UPDATE;
    c.temp_error     = hefd_pkg::ErrW'($urandom);
    c.humid_error    = hefd_pkg::ErrW'($urandom);
    c.manual_request = hefd_pkg::ErrW'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      // mostly aim the excess at the live thresholds, and sometimes the temperature too
      if ($urandom_range(0, 3) != 0) begin
        lo_e = int'(sb.regs.humid_deadband);
        hi_e = int'(sb.regs.humid_full_range);
        if (hi_e < lo_e) begin
          lo_e = hi_e;
          hi_e = int'(sb.regs.humid_deadband);
        end
        lo_e = lo_e - 8;
        hi_e = hi_e + 8;
        c.humid_error = clip16(-(lo_e + int'($urandom_range(0, hi_e - lo_e))));
        lo_t = int'(sb.regs.temp_protect_low);
        hi_t = int'(sb.regs.temp_protect_high);
        if (hi_t < lo_t) begin
          lo_t = hi_t;
          hi_t = int'(sb.regs.temp_protect_low);
        end
        lo_t = lo_t - 16;
        hi_t = hi_t + 16;
        case ($urandom_range(0, 4))
          0, 1: c.temp_error = clip16(lo_t + int'($urandom_range(0, hi_t - lo_t)));
          2, 3: c.temp_error = clip16(-int'($urandom_range(0, 2000)));
          default: ;
        endcase
      end
    end else if (sel < 80) begin
      c.command = hefd_pkg::CMD_MANUAL;
      case ($urandom_range(0, 4))
        0, 1, 2: c.manual_request = clip16(int'($urandom_range(0, 255)));
        3:       c.manual_request = clip16(int'($urandom_range(256, 32767)));
        default: ;
      endcase
    end else if (sel < 94) begin
      c.command        = hefd_pkg::CMD_MANUAL;
      c.manual_request = clip16(-int'($urandom_range(1, 32768)));
    end else if (sel < 97) begin
      c.command = hefd_pkg::CMD_ALARM;
    end else begin
      c.command = CmdUnused;
    end
    return c;
  endfunction

  task automatic drive_cmd(fan_cmd_t c);
    @(negedge clk);
    cmd_if.valid          <= 1'b1;
    cmd_if.command        <= c.command;
    cmd_if.temp_error     <= c.temp_error;
    cmd_if.humid_error    <= c.humid_error;
    cmd_if.manual_request <= c.manual_request;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_cmd(c);
    case (c.command)
      hefd_pkg::CMD_UPDATE: n_update++;
      hefd_pkg::CMD_MANUAL: if (c.manual_request < 0) n_release++; else n_set++;
      hefd_pkg::CMD_ALARM:  n_alarm++;
      default:              n_unused++;
    endcase
  endtask

  task automatic source_idle(int n);
    repeat (n) begin
      @(negedge clk);
      cmd_if.valid       <= 1'b0;
      cmd_if.humid_error <= hefd_pkg::ErrW'($urandom);
    end
  endtask

  task automatic apb_access(logic [hefd_pkg::CfgAddrW-1:0] addr, logic write,
                            logic [hefd_pkg::CfgDataW-1:0] wdata,
                            output logic [hefd_pkg::CfgDataW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(hefd_pkg::reg_e idx, logic [hefd_pkg::ThrW-1:0] v);
    logic [hefd_pkg::CfgAddrW-1:0] addr;
    logic [hefd_pkg::CfgDataW-1:0] rd;
    addr = {idx, 2'b00};
    apb_access(addr, 1'b1, hefd_pkg::CfgDataW'(v), rd);
    sb.write_reg(idx, v);
    n_cfg++;
    apb_access(addr, 1'b0, '0, rd);
    if (rd !== hefd_pkg::CfgDataW'(v))
      sb.report($sformatf("reg %s reads %0d, want %0d", idx.name(), rd, v));
  endtask

  task automatic apply_cfg(hefd_pkg::cfg_t c);
    cfg_write(hefd_pkg::REG_MIN_SPEED, hefd_pkg::ThrW'(c.min_speed));
    cfg_write(hefd_pkg::REG_MAX_SPEED, hefd_pkg::ThrW'(c.max_speed));
    cfg_write(hefd_pkg::REG_STALL_DUTY, hefd_pkg::ThrW'(c.stall_duty));
    cfg_write(hefd_pkg::REG_HUMID_DEAD, c.humid_deadband);
    cfg_write(hefd_pkg::REG_HUMID_FULL, c.humid_full_range);
    cfg_write(hefd_pkg::REG_TEMP_LOW, c.temp_protect_low);
    cfg_write(hefd_pkg::REG_TEMP_HIGH, c.temp_protect_high);
  endtask

  // block is idle once every result is taken
  task automatic drain();
    while (sb.duty_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic hefd_pkg::cfg_t phase_cfg(int p);
    hefd_pkg::cfg_t c;
    c.min_speed         = hefd_pkg::DutyW'($urandom_range(0, 255));
    c.max_speed         = hefd_pkg::DutyW'($urandom_range(0, 255));
    c.stall_duty        = hefd_pkg::DutyW'($urandom_range(0, 120));
    c.humid_deadband    = hefd_pkg::ThrW'($urandom_range(0, 6000));
    c.humid_full_range  = c.humid_deadband + hefd_pkg::ThrW'($urandom_range(1, 8000));
    c.temp_protect_low  = hefd_pkg::ThrW'($urandom_range(0, 1000));
    c.temp_protect_high = c.temp_protect_low + hefd_pkg::ThrW'($urandom_range(1, 2000));
    case (p)
      0: c = '{8'd0, 8'd0, 8'd0, 15'd0, 15'd0, 15'd0, 15'd0};
      1: c = '{8'd255, 8'd255, 8'd255, 15'd25600, 15'd25600, 15'd32767, 15'd32767};
      // floor above ceiling
      2: c = '{8'd200, 8'd120, 8'd30, 15'd256, 15'd1024, 15'd0, 15'd2048};
      // stall above max, full range under deadband, high under low
      3: c = '{8'd10, 8'd60, 8'd100, 15'd1000, 15'd600, 15'd500, 15'd400};
      4: c.humid_full_range = hefd_pkg::ThrW'($urandom_range(0, 25600));
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    fan_cmd_t directed_q[$];
    logic [hefd_pkg::CfgDataW-1:0] rd;
    sb = new();
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    cmd_if.valid          = 1'b0;
    cmd_if.command        = hefd_pkg::CMD_UPDATE;
    cmd_if.temp_error     = '0;
    cmd_if.humid_error    = '0;
    cmd_if.manual_request = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // reset settings: deadband edge, full excess, throttle and stop, manual and alarm paths
    directed_q = '{
      mk(hefd_pkg::CMD_UPDATE, 0, 0, 0),
      mk(hefd_pkg::CMD_UPDATE, 0, -512, 0),
      mk(hefd_pkg::CMD_UPDATE, 0, -513, 0),
      mk(hefd_pkg::CMD_UPDATE, 0, -3840, 0),
      mk(hefd_pkg::CMD_UPDATE, -32768, -32768, 0),
      mk(hefd_pkg::CMD_UPDATE, 32767, -32768, 0),
      mk(hefd_pkg::CMD_UPDATE, 300, -2000, 0),
      mk(hefd_pkg::CMD_UPDATE, 500, -600, 0),
      mk(hefd_pkg::CMD_UPDATE, 512, -3840, 0),
      mk(hefd_pkg::CMD_UPDATE, 128, -3840, 0),
      mk(hefd_pkg::CMD_UPDATE, 0, 32767, 0),
      mk(hefd_pkg::CMD_MANUAL, 0, 0, 0),
      mk(hefd_pkg::CMD_UPDATE, 0, -32768, 0),
      mk(hefd_pkg::CMD_MANUAL, 0, 0, 300),
      mk(hefd_pkg::CMD_MANUAL, 0, 0, 32767),
      mk(hefd_pkg::CMD_MANUAL, 0, 0, 255),
      mk(CmdUnused, -1, -1, -1),
      mk(hefd_pkg::CMD_MANUAL, 0, 0, -1),
      mk(hefd_pkg::CMD_UPDATE, 0, -1000, 0),
      mk(hefd_pkg::CMD_ALARM, 32767, 32767, -32768),
      mk(hefd_pkg::CMD_UPDATE, 32767, -32768, 0),
      mk(hefd_pkg::CMD_MANUAL, 0, 0, -32768),
      mk(hefd_pkg::CMD_MANUAL, 0, 0, 128),
      mk(hefd_pkg::CMD_MANUAL, 0, 0, -5),
      mk(hefd_pkg::CMD_UPDATE, 200, -2500, 0)
    };
    foreach (directed_q[i]) begin
      if ($urandom_range(0, 2) == 0) source_idle($urandom_range(1, 18));
      drive_cmd(directed_q[i]);
    end

    for (int p = 0; p < NumPhases; p++) begin
      source_idle(1);
      drain();
      apply_cfg(phase_cfg(p));
      // an address past the register list must change nothing
      if (p == 2) apb_access(hefd_pkg::CfgAddrW'(28), 1'b1, $urandom, rd);
      no_stall = (p == NumPhases - 1);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (!no_stall && (k % 64) < 40 && $urandom_range(0, 3) == 0)
          source_idle($urandom_range(1, 18));
        drive_cmd(random_cmd());
      end
    end
    source_idle(1);

    while (sb.duty_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("items: %0d updates, %0d manual sets, %0d releases, %0d alarms, %0d unused",
             n_update, n_set, n_release, n_alarm, n_unused);
    $display("%0d results checked over %0d settings, %0d register writes, %0d mismatches",
             sb.results_seen, NumPhases + 1, n_cfg, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/hefd_pkg.sv
rtl/hefd_if.sv
rtl/hefd_div.sv
rtl/hefd_cfg.sv
rtl/humidity_exhaust_fan_duty.sv
test/testbench.sv
